@@ rtl/swm_pkg.sv @@
`timescale 1ns / 1ps

package swm_pkg;

  // Width of the window length register.
  localparam int unsigned WL_BITS = 7;
  localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BACK,
    ST_APPEND
  } swm_state_e;

endpackage

@@ rtl/swm_if.sv @@
`timescale 1ns / 1ps

// Input channel: one sample word per handshake.
interface swm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_of_sequence;

  modport source (output valid, output sample, output start_of_sequence, input ready);
  modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

// Output channel: one window maximum word per handshake.
interface swm_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

@@ rtl/sliding_window_maximum.sv @@
`timescale 1ns / 1ps
// After an accept the block ages out expired entries at the front (FRONT), pops smaller
//   entries at the back (BACK), then appends the sample (APPEND) and, once the window
//   has filled, registers the result; an empty queue or a restart goes straight to APPEND.
//   One word at a time: the single compare unit and one-read-per-cycle queue set the pace.
//   Ready is low while busy and while a finished result waits on a full output register.
// Reset (async, active low): queue empty, position and count zero, window length 1.
module sliding_window_maximum #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swm_pkg::WL_BITS-1:0]     cfg_wdata_i,
  swm_in_if.sink                          in_i,
  swm_out_if.source                       out_o
);
  import swm_pkg::*;

  // Queue index, fill count and sample position (positions wrap at 2*MAX_WINDOW).
  localparam int unsigned IW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW      = $clog2(2 * MAX_WINDOW);
  localparam int unsigned POS_MOD = 2 * MAX_WINDOW;
  localparam int unsigned EW      = (CW > WL_BITS) ? CW : WL_BITS;
  // Shared comparator operand width: fits an order key or an age / length.
  localparam int unsigned KW      = (SAMPLE_BITS > PW) ? SAMPLE_BITS : PW;
  localparam int unsigned MW      = PW + SAMPLE_BITS;

  swm_state_e state_q, state_d;

  logic [WL_BITS-1:0]     wl_q;
  logic [IW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          seen_q, seen_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [SAMPLE_BITS-1:0] front_q, front_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_data_q, out_data_d;

  // Queue store: {position, value} per entry, one write and one read port.
  logic [MW-1:0]          mem [MAX_WINDOW];
  logic [MW-1:0]          rdata_q;
  logic [IW-1:0]          raddr;
  logic                   mem_we;

  logic                   accept;
  logic [CW-1:0]          len;
  logic [EW-1:0]          wl_ext;
  logic [PW-1:0]          rd_pos;
  logic [SAMPLE_BITS-1:0] rd_val;
  logic [PW-1:0]          age;
  logic [KW-1:0]          cmp_a, cmp_b;
  logic                   less;
  logic [IW-1:0]          offset;
  logic [IW-1:0]          slot;
  logic [CW-1:0]          seen_inc;
  logic                   has_result;
  logic                   stall;

  // (head + offset) modulo MAX_WINDOW; both operands are below MAX_WINDOW.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(MAX_WINDOW)) begin
      s = s - (IW+1)'(MAX_WINDOW);
    end
    return s[IW-1:0];
  endfunction

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid      = out_valid_q;
  assign out_o.window_max = out_data_q;

  // Effective window length: zero acts as one, clamp to MAX_WINDOW.
  assign wl_ext = EW'(wl_q);
  always_comb begin
    priority if (wl_ext == '0) begin
      len = CW'(1);
    end else if (wl_ext > EW'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = CW'(wl_ext);
    end
  end

  assign rd_pos = rdata_q[MW-1:SAMPLE_BITS];
  assign rd_val = rdata_q[SAMPLE_BITS-1:0];

  // Age of the front entry, modulo 2*MAX_WINDOW.
  always_comb begin
    if (pos_q >= rd_pos) begin
      age = pos_q - rd_pos;
    end else begin
      age = PW'((PW+1)'(pos_q) + (PW+1)'(POS_MOD) - (PW+1)'(rd_pos));
    end
  end

  // Shared compare unit: age < length at the front, back < new sample at the back.
  always_comb begin
    if (state_q == ST_BACK) begin
      cmp_a = KW'({~rd_val[SAMPLE_BITS-1], rd_val[SAMPLE_BITS-2:0]});
      cmp_b = KW'({~sample_q[SAMPLE_BITS-1], sample_q[SAMPLE_BITS-2:0]});
    end else begin
      cmp_a = KW'(age);
      cmp_b = KW'(len);
    end
  end
  assign less = (cmp_a < cmp_b);

  assign seen_inc   = (seen_q < len) ? seen_q + CW'(1) : len;
  assign has_result = (seen_inc >= len);
  assign stall      = has_result && out_valid_q && !out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (!in_i.start_of_sequence && count_q != '0) ? ST_FRONT : ST_APPEND;
        end
      end
      ST_FRONT: begin
        if (less) begin
          state_d = ST_BACK;
        end else if (count_q == CW'(1)) begin
          state_d = ST_APPEND;
        end
      end
      ST_BACK: begin
        if (!(less && count_q != CW'(1))) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (!stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory addressing.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    seen_d      = seen_q;
    sample_d    = sample_q;
    front_d     = front_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    offset      = '0;
    raddr       = head_q;
    mem_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sample_d = in_i.sample;
          if (in_i.start_of_sequence) begin
            head_d  = '0;
            count_d = '0;
            pos_d   = '0;
            seen_d  = '0;
          end
        end
      end
      ST_FRONT: begin
        if (less) begin
          // front stays; go read the back entry
          front_d = rd_val;
          offset  = IW'(count_q - CW'(1));
          raddr   = slot;
        end else begin
          // front aged out
          offset  = IW'(1);
          head_d  = slot;
          count_d = count_q - CW'(1);
          raddr   = slot;
        end
      end
      ST_BACK: begin
        if (less) begin
          count_d = count_q - CW'(1);
          offset  = IW'(count_q - CW'(2));
          raddr   = slot;
        end
      end
      ST_APPEND: begin
        // fill never reaches MAX_WINDOW here: survivors are younger than the window
        offset = IW'(count_q);
        if (!stall) begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          pos_d   = (pos_q == PW'(POS_MOD - 1)) ? '0 : pos_q + PW'(1);
          seen_d  = seen_inc;
          if (has_result) begin
            out_valid_d = 1'b1;
            out_data_d  = (count_q == '0) ? sample_q : front_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign slot = wrap_add(head_q, offset);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot] <= {pos_q, sample_q};
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wl_q        <= WL_RESET;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    front_q    <= front_d;
    out_data_q <= out_data_d;
  end

endmodule

@@ rtl/swm_checker.sv @@
`timescale 1ns / 1ps

module swm_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_data_i
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("swm: stalled result word changed");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("swm: ready high right after accept");

  // a result is not flagged right after its accept; the append state comes first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("swm: result too early after accept");

  // reset empties the output and leaves the block ready
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i && in_ready_i)
    else $error("swm: bad state in reset");

endmodule

bind sliding_window_maximum swm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.window_max)
);
